[hdl/dgd_pkg.sv]
// ---------------------------------------------------------------------------
// dgd_pkg
// Shared types, constants and CRC byte-update functions for the datagram
// deframer with header and payload CRC checking.
// ---------------------------------------------------------------------------
`default_nettype none

package dgd_pkg;

    // Header lengths in bytes, without and with the payload CRC-32 field
    localparam int unsigned HDR_MIN_LEN = 12;
    localparam int unsigned HDR_EXT_LEN = 16;

    // Byte counter width; it saturates at all ones
    localparam int unsigned COUNT_W = 33;

    // Flags byte: bit carrying the payload-checksum-included flag
    localparam int unsigned FLAG_BIT = 7;

    // Header byte offsets
    localparam int unsigned OFS_BEGIN_LO = 0;
    localparam int unsigned OFS_BEGIN_HI = 1;
    localparam int unsigned OFS_VERSION  = 2;
    localparam int unsigned OFS_FLAGS    = 3;
    localparam int unsigned OFS_LEN_LO   = 4;
    localparam int unsigned OFS_LEN_HI   = 7;
    localparam int unsigned OFS_PCRC_LO  = 8;
    localparam int unsigned OFS_PCRC_HI  = 11;

    // CRC constants (both reflected)
    localparam logic [15:0] CRC16_POLY = 16'hA001;
    localparam logic [15:0] CRC16_INIT = 16'h0000;
    localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;
    localparam logic [31:0] CRC32_XOUT = 32'hFFFFFFFF;

    // Register map: register index taken from paddr above the byte lanes
    localparam int unsigned PADDR_W      = 3;
    localparam logic        REG_BEGIN_MK = 1'b0;

    // End-of-buffer status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_BEGIN = 3'd2,
        ST_HDR_CRC   = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_PAY_CRC   = 3'd5
    } t_status;

    // One result item
    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  payload;
        logic        frame_end;
        t_status     status;
        logic [7:0]  version;
        logic        flag;
        logic [31:0] length;
    } t_result;

    // CRC-16/ARC, one byte, LSB first
    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                   input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // CRC-32 (reflected), one byte, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/dgd_parse.sv]
// ---------------------------------------------------------------------------
// dgd_parse
// Per-frame header capture, running CRCs and status evaluation. Takes one
// byte per cycle while i_accept is high; the byte's result is combinational.
// ---------------------------------------------------------------------------
`default_nettype none

module dgd_parse (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_buffer_last,
    input  wire logic [15:0]      i_marker,
    output logic                  o_has_result,
    output dgd_pkg::t_result      o_result
);
    import dgd_pkg::*;

    // Frame state
    logic [COUNT_W-1:0] r_count;
    logic [15:0]        r_begin_word;
    logic [7:0]         r_version;
    logic               r_flag;
    logic [31:0]        r_length;
    logic [31:0]        r_pay_crc;
    logic [15:0]        r_hdr_crc;
    logic [15:0]        r_crc16;
    logic [31:0]        r_crc32;

    logic [COUNT_W-1:0] n_count;
    logic [15:0]        n_begin_word;
    logic [7:0]         n_version;
    logic               n_flag;
    logic [31:0]        n_length;
    logic [31:0]        n_pay_crc;
    logic [15:0]        n_hdr_crc;
    logic [15:0]        n_crc16;
    logic [31:0]        n_crc32;

    logic [COUNT_W-1:0] hl;
    logic [COUNT_W-1:0] pay_ofs;
    logic               is_payload;
    logic               pay_ok;
    logic [COUNT_W:0]   need_len;
    t_status            status;

    // Field capture and CRC update for this byte
    always_comb begin
        n_flag       = r_flag;
        n_begin_word = r_begin_word;
        n_version    = r_version;
        n_length     = r_length;
        n_pay_crc    = r_pay_crc;
        n_hdr_crc    = r_hdr_crc;
        n_crc16      = r_crc16;
        n_crc32      = r_crc32;

        if (r_count == COUNT_W'(OFS_FLAGS)) begin
            n_flag = i_data_byte[FLAG_BIT];
        end
        hl = n_flag ? COUNT_W'(HDR_EXT_LEN) : COUNT_W'(HDR_MIN_LEN);

        if (r_count < hl - COUNT_W'(2)) begin
            n_crc16 = crc16_arc_byte(r_crc16, i_data_byte);
        end

        if (r_count == COUNT_W'(OFS_BEGIN_LO)) begin
            n_begin_word[7:0] = i_data_byte;
        end else if (r_count == COUNT_W'(OFS_BEGIN_HI)) begin
            n_begin_word[15:8] = i_data_byte;
        end else if (r_count == COUNT_W'(OFS_VERSION)) begin
            n_version = i_data_byte;
        end else if (r_count >= COUNT_W'(OFS_LEN_LO) && r_count <= COUNT_W'(OFS_LEN_HI)) begin
            case (r_count[1:0])
                2'd0:    n_length[7:0]   = i_data_byte;
                2'd1:    n_length[15:8]  = i_data_byte;
                2'd2:    n_length[23:16] = i_data_byte;
                default: n_length[31:24] = i_data_byte;
            endcase
        end else if (n_flag && r_count >= COUNT_W'(OFS_PCRC_LO)
                     && r_count <= COUNT_W'(OFS_PCRC_HI)) begin
            case (r_count[1:0])
                2'd0:    n_pay_crc[7:0]   = i_data_byte;
                2'd1:    n_pay_crc[15:8]  = i_data_byte;
                2'd2:    n_pay_crc[23:16] = i_data_byte;
                default: n_pay_crc[31:24] = i_data_byte;
            endcase
        end

        // Header CRC field: last two bytes of the header
        if (r_count == hl - COUNT_W'(2)) begin
            n_hdr_crc[7:0] = i_data_byte;
        end else if (r_count == hl - COUNT_W'(1)) begin
            n_hdr_crc[15:8] = i_data_byte;
        end

        // Payload window: hl <= count < hl + length
        pay_ofs    = r_count - hl;
        is_payload = (r_count >= hl) && (pay_ofs < {1'b0, n_length});
        if (is_payload) begin
            n_crc32 = crc32_byte(r_crc32, i_data_byte);
        end
        pay_ok = is_payload && (n_begin_word == i_marker) && (n_hdr_crc == n_crc16);

        // Saturating byte count; after this byte it is the buffer length
        n_count = (&r_count) ? r_count : r_count + COUNT_W'(1);
    end

    // End-of-buffer status, first failing check wins
    always_comb begin
        need_len = {2'b00, n_length} + {1'b0, hl};
        if (n_count < COUNT_W'(HDR_MIN_LEN)) begin
            status = ST_TOO_SHORT;
        end else if (n_begin_word != i_marker) begin
            status = ST_BAD_BEGIN;
        end else if (n_flag && n_count < COUNT_W'(HDR_EXT_LEN)) begin
            status = ST_TOO_SHORT;
        end else if (n_hdr_crc != n_crc16) begin
            status = ST_HDR_CRC;
        end else if (need_len > {1'b0, n_count}) begin
            status = ST_OVERFLOW;
        end else if (n_flag && ((n_crc32 ^ CRC32_XOUT) != n_pay_crc)) begin
            status = ST_PAY_CRC;
        end else begin
            status = ST_OK;
        end
    end

    // Result item for this byte
    always_comb begin
        o_has_result        = pay_ok || i_buffer_last;
        o_result.byte_valid = pay_ok;
        o_result.payload    = pay_ok ? i_data_byte : 8'h00;
        o_result.frame_end  = i_buffer_last;
        o_result.status     = i_buffer_last ? status : ST_OK;
        o_result.version    = i_buffer_last ? n_version : 8'h00;
        o_result.flag       = i_buffer_last ? n_flag : 1'b0;
        o_result.length     = i_buffer_last ? n_length : 32'h0;
    end

    // State update; the end of a buffer returns everything to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_buffer_last)) begin
            r_count      <= '0;
            r_begin_word <= '0;
            r_version    <= '0;
            r_flag       <= 1'b0;
            r_length     <= '0;
            r_pay_crc    <= '0;
            r_hdr_crc    <= '0;
            r_crc16      <= CRC16_INIT;
            r_crc32      <= CRC32_INIT;
        end else if (i_accept) begin
            r_count      <= n_count;
            r_begin_word <= n_begin_word;
            r_version    <= n_version;
            r_flag       <= n_flag;
            r_length     <= n_length;
            r_pay_crc    <= n_pay_crc;
            r_hdr_crc    <= n_hdr_crc;
            r_crc16      <= n_crc16;
            r_crc32      <= n_crc32;
        end
    end

endmodule

`default_nettype wire

[hdl/dgd_out_reg.sv]
// ---------------------------------------------------------------------------
// dgd_out_reg
// Result register between the parser and the output channel. Takes a new
// item in the same cycle that the held one is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module dgd_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire dgd_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output dgd_pkg::t_result      o_result,
    output logic                  o_space
);
    import dgd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room for a new item when empty or when the held item leaves now
    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

[hdl/datagram_deframer_crc_check_core.sv]
// ---------------------------------------------------------------------------
// datagram_deframer_crc_check_core
// Datagram deframer: header parse, CRC-16/ARC header check, payload
// pass-through and CRC-32 payload check, with an APB register for the marker.
//
// Input channel (i_valid/o_ready): one buffer byte per item, i_buffer_last on
// the final byte. Output channel (o_valid/i_ready): one item per passed
// payload byte and one on the final byte, which has o_frame_end set with
// status, version, flag and length valid; other bytes give no item.
// o_valid rises in the cycle after acceptance (result register).
// Throughput: one byte per cycle while o_ready is high; both CRC byte updates
// and the status checks sit between the frame state and the result register.
// Stall: with a result held and i_ready low, o_ready drops until it is
// taken; nothing is lost.
// Reset: frame state clears, the output register empties and the begin
// marker returns to zero. The frame state also clears after every buffer end.
// Register 0 (paddr 0): begin marker, bits 15:0, read/write.
// ---------------------------------------------------------------------------
`default_nettype none

module datagram_deframer_crc_check_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // byte input
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_buffer_last,
    // result output
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_byte_valid,
    output logic [7:0]                         o_payload_out,
    output logic                               o_frame_end,
    output logic [2:0]                         o_status,
    output logic [7:0]                         o_version,
    output logic                               o_checksum_included,
    output logic [31:0]                        o_payload_length,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dgd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import dgd_pkg::*;

    logic [15:0] r_marker;
    logic        accept;
    logic        has_result;
    logic        space;
    t_result     res_next;
    t_result     res_out;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_BEGIN_MK) ? {16'h0000, r_marker} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= 16'h0000;
        end else if (psel && penable && pwrite && pready
                     && paddr[PADDR_W-1] == REG_BEGIN_MK) begin
            r_marker <= pwdata[15:0];
        end
    end

    // Input handshake
    assign o_ready = space;
    assign accept  = i_valid && space;

    dgd_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_buffer_last (i_buffer_last),
        .i_marker      (r_marker),
        .o_has_result  (has_result),
        .o_result      (res_next)
    );

    dgd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && has_result),
        .i_result (res_next),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (res_out),
        .o_space  (space)
    );

    // Output fields
    assign o_byte_valid        = res_out.byte_valid;
    assign o_payload_out       = res_out.payload;
    assign o_frame_end         = res_out.frame_end;
    assign o_status            = res_out.status;
    assign o_version           = res_out.version;
    assign o_checksum_included = res_out.flag;
    assign o_payload_length    = res_out.length;

    // Status and header fields only on the closing item
    a_fields_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_end |-> o_status == ST_OK && o_version == 8'h00
                                   && o_payload_length == 32'h0)
        else $error("header fields set on a non-closing item");

    // No payload byte on the closing item without a valid marker and header CRC
    a_pay_hdr_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_valid && o_frame_end |->
            o_status != ST_TOO_SHORT && o_status != ST_BAD_BEGIN
            && o_status != ST_HDR_CRC)
        else $error("payload byte passed from a bad header");

    // Items without payload carry a zero byte; every item has a reason
    a_item_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_valid || o_frame_end)
                    && (o_byte_valid || o_payload_out == 8'h00))
        else $error("result item with no payload and no frame end");

endmodule

`default_nettype wire
